// File: src/ipm_pkg.sv
// ----------------------------------------------------------------------------
// ipm_pkg
// Types, constants and bit-level helper functions shared by the IP prefix
// match pipeline.
// ----------------------------------------------------------------------------
package ipm_pkg;

    localparam int IN_W  = 272;
    localparam int OUT_W = 152;

    localparam logic [31:0] V4_LL_NET   = 32'ha9fe0000;
    localparam logic [31:0] V4_LL_MASK  = 32'hffff0000;
    localparam logic [31:0] V4_P8_MASK  = 32'hff000000;
    localparam logic [31:0] V4_P8_NET   = 32'h0a000000;
    localparam logic [31:0] V4_P12_MASK = 32'hfff00000;
    localparam logic [31:0] V4_P12_NET  = 32'hac100000;
    localparam logic [31:0] V4_P16_MASK = 32'hffff0000;
    localparam logic [31:0] V4_P16_NET  = 32'hc0a80000;
    localparam logic [9:0]  V6_LL_TOP10 = 10'h3fa;

    localparam logic [7:0] V4_MAX_LEN = 8'd32;
    localparam logic [7:0] V6_MAX_LEN = 8'd128;

    // two's complement order codes
    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    typedef struct packed {
        logic        is_v6;
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [63:0] b_hi;
        logic [63:0] b_lo;
        logic [7:0]  match_len;
        logic [7:0]  net_len;
    } in_t;

    typedef struct packed {
        logic         is_v6;
        logic         hi_lt;
        logic         hi_eq;
        logic         lo_lt;
        logic         lo_eq;
        logic         v4_lt;
        logic         v4_eq;
        logic [63:0]  diff_hi;
        logic [63:0]  diff_lo;
        logic [127:0] mdiff;
        logic         merr;
        logic [63:0]  net_hi;
        logic [63:0]  net_lo;
        logic         nerr;
        logic         ll;
        logic         priv;
        logic [5:0]   run_a;
        logic [5:0]   run_b;
    } s1_t;

    typedef struct packed {
        logic        is_v6;
        logic [1:0]  order;
        logic        in_prefix;
        logic        merr;
        logic [7:0]  common;
        logic [5:0]  run_max;
        logic [63:0] net_hi;
        logic [63:0] net_lo;
        logic        nerr;
        logic        ll;
        logic        priv;
    } s2_t;

    // first member is the most significant: order lands in bits 1:0
    typedef struct packed {
        logic [1:0]  pad;
        logic        private_v4;
        logic        link_local;
        logic        net_error;
        logic [63:0] net_lo;
        logic [63:0] net_hi;
        logic        host_prefix_valid;
        logic [5:0]  host_prefix_len;
        logic [7:0]  common_len;
        logic        match_len_error;
        logic        in_prefix;
        logic [1:0]  order;
    } out_t;

    // top n bits set, n in 0..64
    function automatic logic [63:0] top_mask64(logic [6:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 64; i++)
        begin
            m[63-i] = (7'(i) < n);
        end
        return m;
    endfunction

    function automatic logic [6:0] clamp64(logic [7:0] len);
        return (len >= 8'd64) ? 7'd64 : len[6:0];
    endfunction

    function automatic logic [6:0] clamp32(logic [7:0] len);
        return (len >= 8'd32) ? 7'd32 : len[6:0];
    endfunction

    // length left for the low half once the high half is full
    function automatic logic [6:0] rem64(logic [7:0] len);
        logic [7:0] d;
        d = len - 8'd64;
        return (len > 8'd64) ? d[6:0] : 7'd0;
    endfunction

    function automatic logic [6:0] lzc64(logic [63:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = 7'(63 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc32(logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    // length of the run of trailing bits equal to bit 0, 32 for a uniform word
    function automatic logic [5:0] trail_run32(logic [31:0] x);
        logic [31:0] y;
        logic [5:0]  n;
        y = x ^ {32{x[0]}};
        n = 6'd32;
        for (int i = 31; i >= 0; i--)
        begin
            if (y[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

endpackage

// File: src/ipm_cmp_stage.sv
// ----------------------------------------------------------------------------
// ipm_cmp_stage
// First pipeline stage: address differences, compare flags, prefix masks,
// network masking, range flags and IPv4 trailing-run lengths.
// ----------------------------------------------------------------------------
module ipm_cmp_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  ipm_pkg::in_t up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output ipm_pkg::s1_t dn_data
);

    logic         valid_reg;
    ipm_pkg::s1_t data_reg;
    ipm_pkg::s1_t data_next;

    logic [31:0] a32;
    logic [31:0] b32;
    logic [63:0] dh;
    logic [63:0] dl;
    logic [63:0] m32;
    logic [63:0] mm_hi;
    logic [63:0] mm_lo;
    logic [63:0] n32;
    logic [63:0] nm_hi;
    logic [63:0] nm_lo;

    assign a32 = up_data.a_lo[31:0];
    assign b32 = up_data.b_lo[31:0];
    assign dh  = up_data.a_hi ^ up_data.b_hi;
    assign dl  = up_data.a_lo ^ up_data.b_lo;

    assign m32   = ipm_pkg::top_mask64(ipm_pkg::clamp32(up_data.match_len));
    assign mm_hi = ipm_pkg::top_mask64(ipm_pkg::clamp64(up_data.match_len));
    assign mm_lo = ipm_pkg::top_mask64(ipm_pkg::rem64(up_data.match_len));
    assign n32   = ipm_pkg::top_mask64(ipm_pkg::clamp32(up_data.net_len));
    assign nm_hi = ipm_pkg::top_mask64(ipm_pkg::clamp64(up_data.net_len));
    assign nm_lo = ipm_pkg::top_mask64(ipm_pkg::rem64(up_data.net_len));

    always_comb
    begin
        data_next         = '0;
        data_next.is_v6   = up_data.is_v6;
        data_next.hi_lt   = up_data.a_hi < up_data.b_hi;
        data_next.hi_eq   = up_data.a_hi == up_data.b_hi;
        data_next.lo_lt   = up_data.a_lo < up_data.b_lo;
        data_next.lo_eq   = up_data.a_lo == up_data.b_lo;
        data_next.v4_lt   = a32 < b32;
        data_next.v4_eq   = a32 == b32;
        data_next.diff_hi = dh;
        data_next.diff_lo = dl;
        data_next.run_a   = ipm_pkg::trail_run32(a32);
        data_next.run_b   = ipm_pkg::trail_run32(b32);
        if (up_data.is_v6)
        begin
            data_next.merr  = up_data.match_len > ipm_pkg::V6_MAX_LEN;
            data_next.mdiff = {dh & mm_hi, dl & mm_lo};
            data_next.nerr  = (up_data.net_len == 8'd0) ||
                              (up_data.net_len > ipm_pkg::V6_MAX_LEN);
            if (!data_next.nerr)
            begin
                data_next.net_hi = up_data.a_hi & nm_hi;
                data_next.net_lo = up_data.a_lo & nm_lo;
            end
            data_next.ll   = up_data.a_hi[63:54] == ipm_pkg::V6_LL_TOP10;
            data_next.priv = 1'b0;
        end
        else
        begin
            data_next.merr  = up_data.match_len > ipm_pkg::V4_MAX_LEN;
            data_next.mdiff = {96'd0, dl[31:0] & m32[63:32]};
            data_next.nerr  = (up_data.net_len == 8'd0) ||
                              (up_data.net_len > ipm_pkg::V4_MAX_LEN);
            if (!data_next.nerr)
            begin
                data_next.net_lo = {32'd0, a32 & n32[63:32]};
            end
            data_next.ll   = (a32 & ipm_pkg::V4_LL_MASK) == ipm_pkg::V4_LL_NET;
            data_next.priv = ((a32 & ipm_pkg::V4_P8_MASK) == ipm_pkg::V4_P8_NET) ||
                             ((a32 & ipm_pkg::V4_P12_MASK) == ipm_pkg::V4_P12_NET) ||
                             ((a32 & ipm_pkg::V4_P16_MASK) == ipm_pkg::V4_P16_NET);
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: src/ipm_count_stage.sv
// ----------------------------------------------------------------------------
// ipm_count_stage
// Second pipeline stage: numeric order, prefix membership, leading-bit
// count of the difference and the larger IPv4 trailing run.
// ----------------------------------------------------------------------------
module ipm_count_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  ipm_pkg::s1_t up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output ipm_pkg::s2_t dn_data
);

    logic         valid_reg;
    ipm_pkg::s2_t data_reg;
    ipm_pkg::s2_t data_next;

    logic [6:0] lz_hi;
    logic [6:0] lz_lo;

    assign lz_hi = ipm_pkg::lzc64(up_data.diff_hi);
    assign lz_lo = ipm_pkg::lzc64(up_data.diff_lo);

    always_comb
    begin
        data_next           = '0;
        data_next.is_v6     = up_data.is_v6;
        data_next.merr      = up_data.merr;
        data_next.in_prefix = !up_data.merr && !(|up_data.mdiff);
        data_next.net_hi    = up_data.net_hi;
        data_next.net_lo    = up_data.net_lo;
        data_next.nerr      = up_data.nerr;
        data_next.ll        = up_data.ll;
        data_next.priv      = up_data.priv;
        data_next.run_max   = (up_data.run_a > up_data.run_b) ? up_data.run_a
                                                              : up_data.run_b;
        if (up_data.is_v6)
        begin
            if (!up_data.hi_eq)
            begin
                data_next.order = up_data.hi_lt ? ipm_pkg::ORD_LT : ipm_pkg::ORD_GT;
            end
            else if (!up_data.lo_eq)
            begin
                data_next.order = up_data.lo_lt ? ipm_pkg::ORD_LT : ipm_pkg::ORD_GT;
            end
            else
            begin
                data_next.order = ipm_pkg::ORD_EQ;
            end
            if (|up_data.diff_hi)
            begin
                data_next.common = {1'b0, lz_hi};
            end
            else
            begin
                data_next.common = 8'd64 + {1'b0, lz_lo};
            end
        end
        else
        begin
            if (up_data.v4_eq)
            begin
                data_next.order = ipm_pkg::ORD_EQ;
            end
            else
            begin
                data_next.order = up_data.v4_lt ? ipm_pkg::ORD_LT : ipm_pkg::ORD_GT;
            end
            data_next.common = {2'b00, ipm_pkg::lzc32(up_data.diff_lo[31:0])};
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: src/ipm_host_stage.sv
// ----------------------------------------------------------------------------
// ipm_host_stage
// Third pipeline stage: IPv4 host-part prefix shrink and result assembly.
// ----------------------------------------------------------------------------
module ipm_host_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  ipm_pkg::s2_t  up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output ipm_pkg::out_t dn_data
);

    logic          valid_reg;
    ipm_pkg::out_t data_reg;
    ipm_pkg::out_t data_next;

    logic [5:0] common6;
    logic [5:0] cap;
    logic [5:0] hlen;

    assign common6 = up_data.common[5:0];
    assign cap     = 6'd31 - up_data.run_max;

    // Shrinking stops at the first length whose host parts are mixed for
    // both A and B; that length is bounded by 31 minus the longer run.
    always_comb
    begin
        if (common6 >= 6'd31)
        begin
            hlen = common6;
        end
        else if (up_data.run_max >= 6'd31)
        begin
            hlen = 6'd0;
        end
        else
        begin
            hlen = (common6 < cap) ? common6 : cap;
        end
    end

    always_comb
    begin
        data_next                   = '0;
        data_next.order             = up_data.order;
        data_next.in_prefix         = up_data.in_prefix;
        data_next.match_len_error   = up_data.merr;
        data_next.common_len        = up_data.common;
        data_next.host_prefix_len   = up_data.is_v6 ? 6'd0 : hlen;
        data_next.host_prefix_valid = !up_data.is_v6;
        data_next.net_hi            = up_data.net_hi;
        data_next.net_lo            = up_data.net_lo;
        data_next.net_error         = up_data.nerr;
        data_next.link_local        = up_data.ll;
        data_next.private_v4        = up_data.priv;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: src/ipm_skid.sv
// ----------------------------------------------------------------------------
// ipm_skid
// Output register with a skid entry; the upstream ready is a register, so
// the output-side ready does not reach back into the pipeline.
// ----------------------------------------------------------------------------
module ipm_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  ipm_pkg::out_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output ipm_pkg::out_t dn_data
);

    logic          main_valid_reg;
    ipm_pkg::out_t main_reg;
    logic          skid_valid_reg;
    ipm_pkg::out_t skid_reg;
    logic          up_fire;

    assign up_ready = !skid_valid_reg;
    assign up_fire  = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (dn_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= up_fire;
            end
        end
        else if (up_fire)
        begin
            // hold the stalled transaction, park the new one
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dn_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (up_fire)
            begin
                main_reg <= up_data;
            end
        end
        else if (up_fire)
        begin
            skid_reg <= up_data;
        end
    end

    assign dn_valid = main_valid_reg;
    assign dn_data  = main_reg;

endmodule

// File: src/ip_prefix_match_unit.sv
// ----------------------------------------------------------------------------
// ip_prefix_match_unit
// IPv4/IPv6 address compare, prefix match, common-prefix count, network
// masking and address range flags, one transaction per clock when not stalled.
// ----------------------------------------------------------------------------
// The unit takes one address pair per clock while not stalled and returns
// one result per transaction in the same order. Each transaction passes
// through three compute stages (compare and mask, leading-bit count,
// host-prefix shrink) and an output register with a skid entry.
// Throughput is one transaction per cycle when not stalled, set by the
// pipeline having a register at every stage with per-stage valid bits;
// backpressure on the output fills the pipeline and the skid entry before
// input ready drops. In IPv4 mode only bits 31..0 of the low address words are used.
module ip_prefix_match_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // a_hi[63:0], a_lo[127:64], b_hi[191:128], b_lo[255:192],
    // match_len[263:256], net_len[271:264]
    input  logic [ipm_pkg::IN_W-1:0]   s_axis_tdata,
    // is_v6[0]
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // order[1:0], in_prefix[2], match_len_error[3], common_len[11:4],
    // host_prefix_len[17:12], host_prefix_valid[18], net_hi[82:19],
    // net_lo[146:83], net_error[147], link_local[148], private_v4[149],
    // zero fill[151:150]
    output logic [ipm_pkg::OUT_W-1:0]  m_axis_tdata
);

    ipm_pkg::in_t  in_item;
    ipm_pkg::s1_t  s1_data;
    ipm_pkg::s2_t  s2_data;
    ipm_pkg::out_t s3_data;
    ipm_pkg::out_t out_item;

    logic s1_valid;
    logic s1_ready;
    logic s2_valid;
    logic s2_ready;
    logic s3_valid;
    logic s3_ready;

    assign in_item.is_v6     = s_axis_tuser;
    assign in_item.a_hi      = s_axis_tdata[63:0];
    assign in_item.a_lo      = s_axis_tdata[127:64];
    assign in_item.b_hi      = s_axis_tdata[191:128];
    assign in_item.b_lo      = s_axis_tdata[255:192];
    assign in_item.match_len = s_axis_tdata[263:256];
    assign in_item.net_len   = s_axis_tdata[271:264];

    ipm_cmp_stage u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_axis_tvalid),
        .up_ready (s_axis_tready),
        .up_data  (in_item),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    ipm_count_stage u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    ipm_host_stage u_host (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn_data  (s3_data)
    );

    ipm_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .up_data  (s3_data),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .dn_data  (out_item)
    );

    assign m_axis_tdata = out_item;

endmodule
